### rtl/core/assert_macros.svh
// assertion helpers, empty when synthesising
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst, prop)

`define ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

### rtl/core/sbst_pkg.sv
package sbst_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int PIPE_STAGES        = 8;

endpackage

### rtl/core/segment_box_slab_test_top.sv
// segment against axis-aligned box, slab method, exact rational compares
//
// input channel req_*: one word carries segment start and end points and the
// box lower and upper corners, all signed at one fixed-point scale.
// result channel rsp_*: one word per input word, rsp_hit set when any point
// of the segment lies in the closed box (faces count as inside).
//
// one word is accepted every cycle while the receiver takes results. the
// pipeline is a chain of slab updates: prep, x axis, then for y, z and the
// final check a stage of cross products followed by a stage of compare and
// select, ending at rsp_valid.
//
// the pipeline advances as a whole; when rsp_valid is high and rsp_ready is
// low every stage holds and req_ready drops, so nothing is lost or repeated.
// reset clears the stage valid bits only; the block keeps no other state.
`include "assert_macros.svh"

module segment_box_slab_test_top #(
   parameter int COORD_BITS = sbst_pkg::COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_start_z,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   input  logic signed [COORD_BITS-1:0] req_end_z,
   input  logic signed [COORD_BITS-1:0] req_box_min_x,
   input  logic signed [COORD_BITS-1:0] req_box_min_y,
   input  logic signed [COORD_BITS-1:0] req_box_min_z,
   input  logic signed [COORD_BITS-1:0] req_box_max_x,
   input  logic signed [COORD_BITS-1:0] req_box_max_y,
   input  logic signed [COORD_BITS-1:0] req_box_max_z,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_hit
);

   localparam int N  = COORD_BITS;
   localparam int W  = COORD_BITS + 1;
   localparam int P  = 2 * COORD_BITS;
   localparam int NS = sbst_pkg::PIPE_STAGES;

   typedef struct packed {
      logic [N-1:0] den;
      logic [N-1:0] nl;
      logic [N-1:0] nh;
      logic         ent_ok;
      logic         ext_ok;
      logic         miss;
   } axis_type;

   typedef struct packed {
      logic [N-1:0] en;
      logic [N-1:0] ed;
      logic [N-1:0] xn;
      logic [N-1:0] xd;
      logic         miss;
   } run_type;

   typedef struct packed {
      logic [P-1:0] pe_new;
      logic [P-1:0] pe_old;
      logic [P-1:0] px_new;
      logic [P-1:0] px_old;
   } prod_type;

   function automatic axis_type axis_prep(logic signed [N-1:0] s, logic signed [N-1:0] e,
                                          logic signed [N-1:0] lo, logic signed [N-1:0] hi);
      axis_type         a;
      logic signed [W-1:0] d;
      logic signed [W-1:0] lo_s;
      logic signed [W-1:0] hi_s;
      logic signed [W-1:0] nl;
      logic signed [W-1:0] nh;
      logic signed [W-1:0] ad;
      d    = W'(e) - W'(s);
      lo_s = W'(lo) - W'(s);
      hi_s = W'(hi) - W'(s);
      if (d > 0) begin
         ad = d;
         nl = lo_s;
         nh = hi_s;
      end else begin
         ad = -d;
         nl = -hi_s;
         nh = -lo_s;
      end
      a.den = ad[N-1:0];
      a.nl  = nl[N-1:0];
      a.nh  = nh[N-1:0];
      if (d == '0) begin
         a.miss   = (lo_s > 0) || (hi_s < 0);
         a.ent_ok = 1'b0;
         a.ext_ok = 1'b0;
      end else begin
         a.miss   = (nl > ad) || (nh < 0);
         a.ent_ok = (nl > 0);
         a.ext_ok = (nh < ad);
      end
      return a;
   endfunction

   // first axis: running range is still [0,1]
   function automatic run_type run_init(axis_type a);
      run_type r;
      r.en   = a.ent_ok ? a.nl  : '0;
      r.ed   = a.ent_ok ? a.den : N'(1);
      r.xn   = a.ext_ok ? a.nh  : N'(1);
      r.xd   = a.ext_ok ? a.den : N'(1);
      r.miss = a.miss;
      return r;
   endfunction

   function automatic prod_type run_prod(run_type r, axis_type a);
      prod_type p;
      p.pe_new = P'(a.nl) * P'(r.ed);
      p.pe_old = P'(r.en) * P'(a.den);
      p.px_new = P'(a.nh) * P'(r.xd);
      p.px_old = P'(r.xn) * P'(a.den);
      return p;
   endfunction

   function automatic run_type run_update(run_type r, axis_type a, prod_type p);
      run_type q;
      q = r;
      if (a.ent_ok && (p.pe_new > p.pe_old)) begin
         q.en = a.nl;
         q.ed = a.den;
      end
      if (a.ext_ok && (p.px_new < p.px_old)) begin
         q.xn = a.nh;
         q.xd = a.den;
      end
      q.miss = r.miss | a.miss;
      return q;
   endfunction

   logic            advance;
   logic [NS-1:0]   vld_ff;
   logic [NS-1:0]   vld_in;

   axis_type        s1_x_ff, s1_y_ff, s1_z_ff;
   axis_type        s1_x_in, s1_y_in, s1_z_in;
   run_type         s2_run_ff, s2_run_in;
   axis_type        s2_y_ff, s2_z_ff;
   run_type         s3_run_ff;
   axis_type        s3_y_ff, s3_z_ff;
   prod_type        s3_prod_ff, s3_prod_in;
   run_type         s4_run_ff, s4_run_in;
   axis_type        s4_z_ff;
   run_type         s5_run_ff;
   axis_type        s5_z_ff;
   prod_type        s5_prod_ff, s5_prod_in;
   run_type         s6_run_ff, s6_run_in;
   logic [P-1:0]    s7_lhs_ff, s7_rhs_ff, s7_lhs_in, s7_rhs_in;
   logic            s7_miss_ff;
   logic            hit_ff, hit_in;

   assign advance   = !vld_ff[NS-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = vld_ff[NS-1];
   assign rsp_hit   = hit_ff;
   assign vld_in    = {vld_ff[NS-2:0], req_valid};

   always_comb begin
      s1_x_in    = axis_prep(req_start_x, req_end_x, req_box_min_x, req_box_max_x);
      s1_y_in    = axis_prep(req_start_y, req_end_y, req_box_min_y, req_box_max_y);
      s1_z_in    = axis_prep(req_start_z, req_end_z, req_box_min_z, req_box_max_z);
      s2_run_in  = run_init(s1_x_ff);
      s3_prod_in = run_prod(s2_run_ff, s2_y_ff);
      s4_run_in  = run_update(s3_run_ff, s3_y_ff, s3_prod_ff);
      s5_prod_in = run_prod(s4_run_ff, s4_z_ff);
      s6_run_in  = run_update(s5_run_ff, s5_z_ff, s5_prod_ff);
      s7_lhs_in  = P'(s6_run_ff.en) * P'(s6_run_ff.xd);
      s7_rhs_in  = P'(s6_run_ff.xn) * P'(s6_run_ff.ed);
      hit_in     = !s7_miss_ff && (s7_lhs_ff <= s7_rhs_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_x_ff    <= s1_x_in;
         s1_y_ff    <= s1_y_in;
         s1_z_ff    <= s1_z_in;
         s2_run_ff  <= s2_run_in;
         s2_y_ff    <= s1_y_ff;
         s2_z_ff    <= s1_z_ff;
         s3_run_ff  <= s2_run_ff;
         s3_y_ff    <= s2_y_ff;
         s3_z_ff    <= s2_z_ff;
         s3_prod_ff <= s3_prod_in;
         s4_run_ff  <= s4_run_in;
         s4_z_ff    <= s3_z_ff;
         s5_run_ff  <= s4_run_ff;
         s5_z_ff    <= s4_z_ff;
         s5_prod_ff <= s5_prod_in;
         s6_run_ff  <= s6_run_in;
         s7_lhs_ff  <= s7_lhs_in;
         s7_rhs_ff  <= s7_rhs_in;
         s7_miss_ff <= s6_run_ff.miss;
         hit_ff     <= hit_in;
      end
   end

   // checks
   `ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && req_ready, vld_ff[0])
   `ASSERT_NEXT(a_stall_freezes, clock, reset, rsp_valid && !rsp_ready, $stable(vld_ff))
   `ASSERT_CLK(a_den_nonzero, clock, reset, vld_ff[5] |-> (s6_run_ff.ed != '0 && s6_run_ff.xd != '0))

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int CW        = sbst_pkg::COORD_BITS_DEFAULT;
   localparam int HOLD_LEN  = 60;
   localparam int N_RANDOM  = 250;

   typedef logic signed [CW-1:0] coord_type;
   typedef longint unsigned u64_type;

   localparam coord_type C_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam coord_type C_MAX = {1'b0, {(CW-1){1'b1}}};

   typedef struct {
      coord_type p0[3];
      coord_type p1[3];
      coord_type bmin[3];
      coord_type bmax[3];
   } seg_box_type;

   typedef struct {
      seg_box_type w;
      bit          known;
      bit          hit;
   } dir_row_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   coord_type req_start_x = '0;
   coord_type req_start_y = '0;
   coord_type req_start_z = '0;
   coord_type req_end_x = '0;
   coord_type req_end_y = '0;
   coord_type req_end_z = '0;
   coord_type req_box_min_x = '0;
   coord_type req_box_min_y = '0;
   coord_type req_box_min_z = '0;
   coord_type req_box_max_x = '0;
   coord_type req_box_max_y = '0;
   coord_type req_box_max_z = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   logic      rsp_hit;

   bit     touch_q[$];
   bit     want_hit;
   int     err_count = 0;
   int     send_idle_pct = 0;
   int     recv_idle_pct = 0;
   int     hold_asks = 0;
   int     holds_done = 0;
   int     hold_left = 0;

   // segment, box, whether the answer is typed in, typed answer
   dir_row_type dir_tab[18] = '{
      '{'{'{-100, -100, -100}, '{100, 100, 100}, '{-10, -10, -10}, '{10, 10, 10}}, 1, 1},
      '{'{'{-100, 50, 0}, '{100, 50, 0}, '{-10, -10, -10}, '{10, 10, 10}}, 1, 0},
      '{'{'{5, 5, 5}, '{5, 5, 5}, '{-10, -10, -10}, '{10, 10, 10}}, 1, 1},
      '{'{'{11, 0, 0}, '{11, 0, 0}, '{-10, -10, -10}, '{10, 10, 10}}, 1, 0},
      '{'{'{10, -10, 0}, '{10, -10, 0}, '{-10, -10, -10}, '{10, 10, 10}}, 1, 1},
      '{'{'{-100, -100, -100}, '{100, 100, 100}, '{10, -10, -10}, '{-10, 10, 10}}, 1, 0},
      '{'{'{-32768, -32768, -32768}, '{32767, 32767, 32767},
          '{-32768, -32768, -32768}, '{32767, 32767, 32767}}, 1, 1},
      '{'{'{32767, 32767, 32767}, '{-32768, -32768, -32768}, '{0, 0, 0}, '{0, 0, 0}}, 0, 0},
      '{'{'{-20, -20, -20}, '{-10, -10, -10}, '{-10, -10, -10}, '{10, 10, 10}}, 1, 1},
      '{'{'{-20, -20, -20}, '{-11, -11, -11}, '{-10, -10, -10}, '{10, 10, 10}}, 1, 0},
      '{'{'{-20, 0, 0}, '{0, 20, 0}, '{-10, -10, -10}, '{10, 10, 10}}, 0, 0},
      '{'{'{-21, 0, 0}, '{0, 21, 0}, '{-10, -10, -10}, '{10, 10, 10}}, 0, 0},
      '{'{'{-32768, -32768, -32768}, '{-32768, -32768, -32768},
          '{-32768, -32768, -32768}, '{-32768, -32768, -32768}}, 1, 1},
      '{'{'{32767, 32767, 32767}, '{32767, 32767, 32767},
          '{32767, 32767, 32767}, '{32767, 32767, 32767}}, 1, 1},
      '{'{'{0, 100, 0}, '{0, -100, 0}, '{-1, 50, -1}, '{1, 60, 1}}, 1, 1},
      '{'{'{-5, -5, 3}, '{5, 5, 3}, '{0, 0, 3}, '{0, 0, 3}}, 0, 0},
      '{'{'{0, 0, 0}, '{0, 0, 0}, '{0, 0, 1}, '{0, 0, -1}}, 1, 0},
      '{'{'{-32768, 32767, 0}, '{32767, -32768, 0}, '{-1, -1, 0}, '{0, 0, 0}}, 0, 0}
   };

   segment_box_slab_test_top u_top (.*);

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // slab test with exact rational entry and exit parameters
   function automatic bit seg_box_touch(input seg_box_type w);
      u64_type t_in_n, t_in_d, t_out_n, t_out_d, den;
      longint  d, n_lo, n_hi;
      t_in_n  = 0;
      t_in_d  = 1;
      t_out_n = 1;
      t_out_d = 1;
      for (int a = 0; a < 3; a++) begin
         d = longint'(w.p1[a]) - longint'(w.p0[a]);
         if (d == 0) begin
            if (w.p0[a] < w.bmin[a] || w.p0[a] > w.bmax[a])
               return 1'b0;
            continue;
         end
         if (d > 0) begin
            den  = u64_type'(d);
            n_lo = longint'(w.bmin[a]) - longint'(w.p0[a]);
            n_hi = longint'(w.bmax[a]) - longint'(w.p0[a]);
         end else begin
            den  = u64_type'(-d);
            n_lo = longint'(w.p0[a]) - longint'(w.bmax[a]);
            n_hi = longint'(w.p0[a]) - longint'(w.bmin[a]);
         end
         if (n_lo > longint'(den))
            return 1'b0;
         if (n_lo > 0 && u64_type'(n_lo) * t_in_d > t_in_n * den) begin
            t_in_n = u64_type'(n_lo);
            t_in_d = den;
         end
         if (n_hi < 0)
            return 1'b0;
         if (n_hi < longint'(den) && u64_type'(n_hi) * t_out_d < t_out_n * den) begin
            t_out_n = u64_type'(n_hi);
            t_out_d = den;
         end
      end
      return (t_in_n * t_out_d <= t_out_n * t_in_d);
   endfunction

   function automatic coord_type extreme_coord();
      case ($urandom_range(6))
         0: return C_MIN;
         1: return C_MIN + coord_type'(1);
         2: return coord_type'(-1);
         3: return coord_type'(0);
         4: return coord_type'(1);
         5: return C_MAX - coord_type'(1);
         default: return C_MAX;
      endcase
   endfunction

   // mostly segments aimed at or just past a box, some raw bits and extremes
   function automatic seg_box_type rand_word();
      seg_box_type w;
      int kind, how, span, ctr, half, tgt, dlt;
      kind = $urandom_range(9);
      how  = $urandom_range(2);
      span = ($urandom_range(7) == 0) ? 12000 : 200;
      for (int a = 0; a < 3; a++) begin
         if (kind < 2) begin
            w.p0[a]   = coord_type'($urandom);
            w.p1[a]   = coord_type'($urandom);
            w.bmin[a] = coord_type'($urandom);
            w.bmax[a] = coord_type'($urandom);
         end else if (kind == 2) begin
            w.p0[a]   = extreme_coord();
            w.p1[a]   = ($urandom_range(3) == 0) ? w.p0[a] : extreme_coord();
            w.bmin[a] = extreme_coord();
            w.bmax[a] = extreme_coord();
         end else begin
            ctr  = int'($urandom_range(2 * span)) - span;
            half = int'($urandom_range(span / 4));
            tgt  = ctr + int'($urandom_range(2 * half + 4)) - half - 2;
            dlt  = int'($urandom_range(2 * span)) - span;
            if ($urandom_range(5) == 0)
               dlt = 0;
            case (how)
               0: begin
                  w.p0[a] = coord_type'(tgt + dlt);
                  w.p1[a] = coord_type'(tgt - dlt);
               end
               1: begin
                  w.p0[a] = coord_type'(tgt + dlt);
                  w.p1[a] = coord_type'(tgt);
               end
               default: begin
                  w.p0[a] = coord_type'(tgt);
                  w.p1[a] = coord_type'(tgt - dlt);
               end
            endcase
            w.bmin[a] = coord_type'(ctr - half);
            w.bmax[a] = coord_type'(ctr + half);
            if ($urandom_range(19) == 0) begin
               w.bmin[a] = coord_type'(ctr + half + 1);
               w.bmax[a] = coord_type'(ctr - half);
            end
         end
      end
      return w;
   endfunction

   task automatic offer(input seg_box_type w, input bit known, input bit typed_hit);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_start_x   <= w.p0[0];
      req_start_y   <= w.p0[1];
      req_start_z   <= w.p0[2];
      req_end_x     <= w.p1[0];
      req_end_y     <= w.p1[1];
      req_end_z     <= w.p1[2];
      req_box_min_x <= w.bmin[0];
      req_box_min_y <= w.bmin[1];
      req_box_min_z <= w.bmin[2];
      req_box_max_x <= w.bmax[0];
      req_box_max_y <= w.bmax[1];
      req_box_max_z <= w.bmax[2];
      do
         @(posedge clock);
      while (!req_ready);
      touch_q.insert(touch_q.size(), known ? typed_hit : seg_box_touch(w));
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (touch_q.size() != 0);
   endtask

   // receiver, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_asks != holds_done) begin
         holds_done <= hold_asks;
         hold_left  <= HOLD_LEN;
         rsp_ready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (touch_q.size() == 0) begin
            $error("unexpected word: rsp_hit actual %0b", rsp_hit);
            err_count++;
         end else begin
            want_hit = touch_q.pop_front();
            if (rsp_hit !== want_hit) begin
               $error("rsp_hit mismatch: expected %0b, actual %0b", want_hit, rsp_hit);
               err_count++;
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      recv_idle_pct <= 51;
      foreach (dir_tab[i])
         offer(dir_tab[i].w, dir_tab[i].known, dir_tab[i].hit);
      for (int n = 0; n < N_RANDOM - $size(dir_tab); n++)
         offer(rand_word(), 1'b0, 1'b0);
      pause_until_drained();

      send_idle_pct = 51;
      recv_idle_pct <= 20;
      for (int n = 0; n < N_RANDOM; n++)
         offer(rand_word(), 1'b0, 1'b0);
      pause_until_drained();

      // no idling, receiver holds off at the start so the pipe fills
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      hold_asks     <= hold_asks + 1;
      for (int n = 0; n < N_RANDOM; n++)
         offer(rand_word(), 1'b0, 1'b0);
      pause_until_drained();

      repeat (sbst_pkg::PIPE_STAGES + 4) @(posedge clock);
      if (err_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

   initial begin
      #5000000;
      $display("tb_top failed");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/sbst_pkg.sv
rtl/core/segment_box_slab_test_top.sv
tb/tb_top.sv
